// File: design/lif_pkg.sv
// ----------------------------------------------------------------------------
// lif_pkg
// Types and constants shared by the leaky integrate-and-fire update block.
// ----------------------------------------------------------------------------
package lif_pkg;

	localparam int IDX_W   = 8;
	localparam int V_W     = 16;
	localparam int GAIN_W  = 16;
	localparam int REFR_W  = 8;
	localparam int CFG_W   = 16;
	localparam int REG_W   = 3;
	// Number of neurons that an 8-bit index can name.
	localparam int INDEX_SPACE = 256;

	localparam logic [REG_W-1:0] REG_REST      = 3'd0;
	localparam logic [REG_W-1:0] REG_RESET     = 3'd1;
	localparam logic [REG_W-1:0] REG_THRESHOLD = 3'd2;
	localparam logic [REG_W-1:0] REG_LEAK_GAIN = 3'd3;
	localparam logic [REG_W-1:0] REG_IN_GAIN   = 3'd4;
	localparam logic [REG_W-1:0] REG_REFR      = 3'd5;

	localparam logic signed [V_W-1:0]  REST_RST      = -16'sd16640;
	localparam logic signed [V_W-1:0]  RESET_RST     = -16'sd16640;
	localparam logic signed [V_W-1:0]  THRESHOLD_RST = -16'sd14080;
	localparam logic [GAIN_W-1:0]      LEAK_GAIN_RST = 16'd256;
	localparam logic [GAIN_W-1:0]      IN_GAIN_RST   = 16'd256;
	localparam logic [REFR_W-1:0]      REFR_RST      = 8'd2;

	typedef struct packed {
		logic signed [V_W-1:0] rest;
		logic signed [V_W-1:0] reset_v;
		logic signed [V_W-1:0] threshold;
		logic [GAIN_W-1:0]     leak_gain;
		logic [GAIN_W-1:0]     input_gain;
		logic [REFR_W-1:0]     refr_steps;
	} lif_cfg_t;

	// One neuron's stored state.
	typedef struct packed {
		logic signed [V_W-1:0] v;
		logic [REFR_W-1:0]     refr;
	} lif_state_t;

	localparam int STATE_W = V_W + REFR_W;

endpackage

// File: design/lif_ram.sv
// ----------------------------------------------------------------------------
// lif_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lif_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic                                     rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: design/lif_core.sv
// ----------------------------------------------------------------------------
// lif_core
// Combinational neuron update: leak and input integration, saturation,
// threshold test and refractory countdown.
// ----------------------------------------------------------------------------
module lif_core (
	input  lif_pkg::lif_cfg_t                cfg,
	input  logic                             in_range,
	input  lif_pkg::lif_state_t              state_old,
	input  logic signed [lif_pkg::V_W-1:0]   current,
	output lif_pkg::lif_state_t              state_new,
	output logic                             spiked,
	output logic                             refractory,
	output logic signed [lif_pkg::V_W-1:0]   potential
);
	import lif_pkg::*;

	logic signed [V_W:0]    diff;
	logic signed [33:0]     leak_p;
	logic signed [33:0]     in_p;
	logic signed [34:0]     acc;
	logic signed [26:0]     delta;
	logic signed [27:0]     v_sum;
	logic signed [V_W-1:0]  v_sat;

	assign diff   = {cfg.rest[V_W-1], cfg.rest} - {state_old.v[V_W-1], state_old.v};
	assign leak_p = 34'($signed({1'b0, cfg.leak_gain})) * 34'(diff);
	assign in_p   = 34'($signed({1'b0, cfg.input_gain})) * 34'(current);
	assign acc    = {leak_p[33], leak_p} + {in_p[33], in_p};
	// Dropping the low byte of a two's complement value rounds towards minus infinity.
	assign delta  = acc[34:8];
	assign v_sum  = {delta[26], delta} + {{12{state_old.v[V_W-1]}}, state_old.v};

	always_comb begin
		if (v_sum > 28'sd32767) begin
			v_sat = 16'sh7fff;
		end else if (v_sum < -28'sd32768) begin
			v_sat = 16'sh8000;
		end else begin
			v_sat = v_sum[V_W-1:0];
		end
	end

	always_comb begin
		state_new  = state_old;
		spiked     = 1'b0;
		refractory = 1'b0;
		potential  = '0;
		if (in_range) begin
			if (state_old.refr != '0) begin
				state_new.refr = state_old.refr - 1'b1;
				state_new.v    = cfg.rest;
				refractory     = 1'b1;
			end else if (v_sat >= cfg.threshold) begin
				state_new.refr = cfg.refr_steps;
				state_new.v    = cfg.reset_v;
				spiked         = 1'b1;
			end else begin
				state_new.v = v_sat;
			end
			potential = state_new.v;
		end
	end

endmodule

// File: design/lif_neuron_update.sv
// ----------------------------------------------------------------------------
// lif_neuron_update
// Leaky integrate-and-fire neuron array: one state update per in-range request.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  input   | in_valid / in_ready  | neuron_index, input_current
//  output  | out_valid/ out_ready | out_neuron_index, spiked, new_potential,
//          |                      | in_refractory
//  config  | cfg_write            | cfg_index, cfg_data
//
// One request is taken per cycle while input ready is high; its result passes
// through the update stage register and then the result register. The state
// RAM read is registered at the accepting edge, and the update logic lies
// between the read data and the result register. Back-to-back requests to the
// same neuron take the freshly written state from a bypass register. Reset
// clears the per-neuron valid bits, so unwritten neurons read as zero with no
// clearing pass. A stalled output holds the update stage, and input ready falls
// only when both stages are full and the result is not taken.
// ----------------------------------------------------------------------------
module lif_neuron_update #(
	parameter int NEURONS = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [lif_pkg::REG_W-1:0]           cfg_index,
	input  logic [lif_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [lif_pkg::IDX_W-1:0]           neuron_index,
	input  logic signed [lif_pkg::V_W-1:0]      input_current,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [lif_pkg::IDX_W-1:0]           out_neuron_index,
	output logic                                spiked,
	output logic signed [lif_pkg::V_W-1:0]      new_potential,
	output logic                                in_refractory
);
	import lif_pkg::*;

	localparam int DEPTH  = (NEURONS < INDEX_SPACE) ? NEURONS : INDEX_SPACE;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	lif_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rest       <= REST_RST;
			cfg_q.reset_v    <= RESET_RST;
			cfg_q.threshold  <= THRESHOLD_RST;
			cfg_q.leak_gain  <= LEAK_GAIN_RST;
			cfg_q.input_gain <= IN_GAIN_RST;
			cfg_q.refr_steps <= REFR_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_REST:      cfg_q.rest       <= cfg_data;
				REG_RESET:     cfg_q.reset_v    <= cfg_data;
				REG_THRESHOLD: cfg_q.threshold  <= cfg_data;
				REG_LEAK_GAIN: cfg_q.leak_gain  <= cfg_data;
				REG_IN_GAIN:   cfg_q.input_gain <= cfg_data;
				REG_REFR:      cfg_q.refr_steps <= cfg_data[REFR_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake and stage control.
	logic in_fire;
	logic s1_vld_q;
	logic s1_adv;
	logic out_vld_q;

	assign s1_adv   = s1_vld_q && (!out_vld_q || out_ready);
	assign in_ready = !s1_vld_q || s1_adv;
	assign in_fire  = in_valid && in_ready;

	// Write-back path.
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	lif_state_t        wr_state;

	logic [ADDR_W-1:0] rd_addr;
	logic              in_range;
	logic [STATE_W-1:0] ram_rd;

	assign rd_addr  = neuron_index[ADDR_W-1:0];
	assign in_range = ({24'd0, neuron_index} < NEURONS);

	lif_ram #(
		.WIDTH (STATE_W),
		.DEPTH (DEPTH)
	) u_state_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_state),
		.rd_en   (in_fire),
		.rd_addr (rd_addr),
		.rd_data (ram_rd)
	);

	// Valid bit per neuron: an entry never written reads as the zero reset state.
	logic [DEPTH-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// Update stage.
	logic [IDX_W-1:0]      idx_s1;
	logic signed [V_W-1:0] cur_s1;
	logic                  range_s1;
	logic                  ent_vld_s1;
	logic                  byp_hit_s1;
	lif_state_t            byp_state_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (in_fire) begin
			s1_vld_q <= 1'b1;
		end else if (s1_adv) begin
			s1_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			idx_s1       <= neuron_index;
			cur_s1       <= input_current;
			range_s1     <= in_range;
			ent_vld_s1   <= in_range && vld_q[rd_addr];
			// A write at this same edge is not yet visible in the RAM read data.
			byp_hit_s1   <= wr_en && (wr_addr == rd_addr);
			byp_state_s1 <= wr_state;
		end
	end

	lif_state_t            state_old;
	lif_state_t            state_new;
	logic                  core_spiked;
	logic                  core_refr;
	logic signed [V_W-1:0] core_v;

	always_comb begin
		if (byp_hit_s1) begin
			state_old = byp_state_s1;
		end else if (ent_vld_s1) begin
			state_old = ram_rd;
		end else begin
			state_old = '0;
		end
	end

	lif_core u_core (
		.cfg        (cfg_q),
		.in_range   (range_s1),
		.state_old  (state_old),
		.current    (cur_s1),
		.state_new  (state_new),
		.spiked     (core_spiked),
		.refractory (core_refr),
		.potential  (core_v)
	);

	assign wr_en    = s1_adv && range_s1;
	assign wr_addr  = idx_s1[ADDR_W-1:0];
	assign wr_state = state_new;

	// Result register.
	logic [IDX_W-1:0]      out_idx_q;
	logic                  out_spk_q;
	logic signed [V_W-1:0] out_v_q;
	logic                  out_refr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_adv) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_idx_q  <= idx_s1;
			out_spk_q  <= core_spiked;
			out_v_q    <= core_v;
			out_refr_q <= core_refr;
		end
	end

	assign out_valid        = out_vld_q;
	assign out_neuron_index = out_idx_q;
	assign spiked           = out_spk_q;
	assign new_potential    = out_v_q;
	assign in_refractory    = out_refr_q;

	// A neuron cannot fire on a step that it spends refractory.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> !(out_spk_q && out_refr_q))
		else $error("spike reported on a refractory step");

	// A spiking neuron is left at the reset potential.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_spk_q) |-> (out_v_q == cfg_q.reset_v))
		else $error("spike without reset potential");

	// A refractory neuron is held at rest.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_refr_q) |-> (out_v_q == cfg_q.rest))
		else $error("refractory step not at rest potential");

	// State is written only for a valid, in-range update leaving the stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (s1_vld_q && range_s1))
		else $error("state write without a valid update");

	// An out-of-range request leaves a result with no spike, no refractory flag and zero potential.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && !range_s1) |=> (out_vld_q && !out_spk_q && !out_refr_q && out_v_q == '0))
		else $error("out-of-range result not cleared");

endmodule
